[hdl/sqp_pkg.sv]
package sqp_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int OCC_W     = 5;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} entry_t;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		ACT_ENQ = 1'b0,
		ACT_DEQ = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_ENQ   = 2'd1,
		OP_DEQ   = 2'd2
	} cell_op_t;

	// broadcast to every cell each cycle
	typedef struct packed {
		cell_op_t op;
		entry_t   ent;
	} cell_ctl_t;

endpackage

[hdl/sqp_in_if.sv]
interface sqp_in_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] item_value;
	logic signed [15:0] item_priority;

	modport source (output valid, action, item_value, item_priority, input ready);
	modport sink   (input valid, action, item_value, item_priority, output ready);
endinterface

[hdl/sqp_out_if.sv]
interface sqp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic signed [15:0] out_priority;
	logic [4:0]         occupancy;

	modport source (output valid, status, out_value, out_priority, occupancy, input ready);
	modport sink   (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

[hdl/sqp_cell.sv]
module sqp_cell import sqp_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occ,       // slot holds a live entry
	input  logic      left_le,   // left neighbor stays put on insert
	input  entry_t    left_ent,
	input  entry_t    right_ent,
	output entry_t    ent_q,
	output logic      le
);

	// live and not behind the new entry's priority
	always_comb begin
		le = occ && ($signed(ent_q.prio) <= $signed(ctl.ent.prio));
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_ENQ: begin
				if (!le) begin
					ent_q <= left_le ? ctl.ent : left_ent;
				end
			end
			OP_DEQ: begin
				ent_q <= right_ent;
			end
			default: begin
				ent_q <= ent_q;
			end
		endcase
	end

endmodule

[hdl/sorted_priority_queue.sv]
// Sorted priority queue, a row of DEPTH cells kept in priority order from the head.
// req channel: one beat is one operation; action 0 enqueues {item_value,
// item_priority}, action 1 dequeues the head. Lower priority values leave first,
// equal priorities leave in arrival order.
// rsp channel: exactly one beat per req beat, carrying status (enqueued, dequeued,
// empty, full), the removed entry (zero unless dequeued) and occupancy afterward.
// The rsp beat is valid in the cycle after the req beat is taken.
// Throughput: one operation per cycle while rsp beats are taken. Every cell compares its
// priority with the incoming one in parallel and then keeps, takes the new entry, or
// takes a neighbor's entry, so an insert or removal is done by all cells at once.
// The rsp output register decouples the sides: req stays ready while the
// held rsp beat is being taken in the same cycle; only a stalled, full output
// register drops req.ready.
// Reset (arst_n low) empties the queue at once: occupancy goes to zero and no
// clearing pass runs; cell contents are left as they are and are never read
// beyond the occupancy.
module sorted_priority_queue import sqp_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	sqp_in_if.sink    req,
	sqp_out_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	status_t          status_q;
	entry_t           head_out_q;
	logic [OCC_W-1:0] occ_out_q;

	entry_t    ent   [DEPTH];
	logic      le    [DEPTH];
	cell_ctl_t ctl;
	logic      fire;
	logic      is_empty;
	logic      is_full;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == FULL_CNT);

	// command broadcast to the cell row
	always_comb begin
		ctl.ent.value = req.item_value;
		ctl.ent.prio  = req.item_priority;
		ctl.op        = OP_HOLD;
		if (fire) begin
			if (req.action == ACT_DEQ) begin
				if (!is_empty) begin
					ctl.op = OP_DEQ;
				end
			end else if (!is_full) begin
				ctl.op = OP_ENQ;
			end
		end
	end

	// cell row; slot 0 is the head
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic   occ;
		logic   left_le;
		entry_t left_ent;
		entry_t right_ent;

		assign occ = (IDX < count_q);

		if (i == 0) begin : g_head
			assign left_le  = 1'b1;
			assign left_ent = ctl.ent;
		end else begin : g_mid
			assign left_le  = le[i-1];
			assign left_ent = ent[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_ent = ent[i];
		end else begin : g_body
			assign right_ent = ent[i+1];
		end

		sqp_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ),
			.left_le   (left_le),
			.left_ent  (left_ent),
			.right_ent (right_ent),
			.ent_q     (ent[i]),
			.le        (le[i])
		);
	end

	// occupancy and the rsp output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= ST_ENQUEUED;
			head_out_q  <= '0;
			occ_out_q   <= '0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
				case (ctl.op)
					OP_ENQ: begin
						count_q    <= count_q + CNT_W'(1);
						status_q   <= ST_ENQUEUED;
						head_out_q <= '0;
						occ_out_q  <= OCC_W'(count_q + CNT_W'(1));
					end
					OP_DEQ: begin
						count_q    <= count_q - CNT_W'(1);
						status_q   <= ST_DEQUEUED;
						head_out_q <= ent[0];
						occ_out_q  <= OCC_W'(count_q - CNT_W'(1));
					end
					default: begin
						status_q   <= (req.action == ACT_DEQ) ? ST_EMPTY : ST_FULL;
						head_out_q <= '0;
						occ_out_q  <= OCC_W'(count_q);
					end
				endcase
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_value    = head_out_q.value;
	assign rsp.out_priority = head_out_q.prio;
	assign rsp.occupancy    = occ_out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("occupancy above depth");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("accepted beat produced no response");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_DEQ) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("dequeue did not decrement occupancy");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> ($signed(ent[0].prio) <= $signed(ent[1].prio)))
		else $error("head entries out of priority order");
`endif

endmodule
